[rtl/crd_pkg.sv]
// Shared types and result codes for the compact record decoder.
`default_nettype none

package crd_pkg;

  typedef enum logic [2:0] {
    KIND_COUNT = 3'd0,
    KIND_UNS   = 3'd1,
    KIND_SGN   = 3'd2,
    KIND_CHAR  = 3'd3,
    KIND_EMPTY = 3'd4
  } kind_e;

  localparam logic [1:0] TYPE_UNS = 2'd0;
  localparam logic [1:0] TYPE_SGN = 2'd1;

  localparam logic [4:0] MAX_NUM_BYTES = 5'd4;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    logic        end_of_field;
    logic        last_in_record;
    logic        last_record;
    logic        length_error;
  } result_t;

endpackage

`default_nettype wire

[rtl/crd_core.sv]
// Record decoder state machine: one stream byte per step, at most one result.
`default_nettype none

module crd_core (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               step_i,
  input  wire  [7:0]        byte_i,
  output logic              res_valid_o,
  output crd_pkg::result_t  res_o
);
  import crd_pkg::*;

  typedef enum logic [1:0] {
    PH_COUNT  = 2'd0,
    PH_HEADER = 2'd1,
    PH_NUMBER = 2'd2,
    PH_STRING = 2'd3
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  records_left_q, records_left_d;
  logic [5:0]  bytes_left_q, bytes_left_d;
  logic [31:0] acc_q, acc_d;
  logic [4:0]  field_size_q, field_size_d;
  logic        signed_q, signed_d;
  logic        last_q, last_d;

  logic [1:0]  hdr_type;
  logic [7:0]  rec_dec;
  logic [5:0]  left_dec;
  logic [31:0] acc_shift;
  logic [31:0] num_value;
  logic        field_last;
  logic        close_last_rec;
  phase_e      close_phase;

  assign hdr_type   = byte_i[6:5];
  assign rec_dec    = records_left_q - 8'd1;
  assign left_dec   = bytes_left_q - 6'd1;
  assign acc_shift  = {acc_q[23:0], byte_i};
  assign field_last = (phase_q == PH_HEADER) ? byte_i[7] : last_q;

  // field close, for the field whose header bit 7 is in field_last
  always_comb begin
    close_last_rec = 1'b0;
    close_phase    = PH_HEADER;
    if (field_last && rec_dec == 8'd0) begin
      close_last_rec = 1'b1;
      close_phase    = PH_COUNT;
    end
  end

  always_comb begin
    num_value = acc_shift;
    if (signed_q) begin
      case (field_size_q)
        5'd1:    num_value = {{24{acc_shift[7]}}, acc_shift[7:0]};
        5'd2:    num_value = {{16{acc_shift[15]}}, acc_shift[15:0]};
        5'd3:    num_value = {{8{acc_shift[23]}}, acc_shift[23:0]};
        default: num_value = acc_shift;
      endcase
    end
  end

  always_comb begin
    phase_d        = phase_q;
    records_left_d = records_left_q;
    bytes_left_d   = bytes_left_q;
    acc_d          = acc_q;
    field_size_d   = field_size_q;
    signed_d       = signed_q;
    last_d         = last_q;
    res_valid_o    = 1'b0;
    res_o          = '{kind: KIND_COUNT, value: '0, end_of_field: 1'b0,
                       last_in_record: 1'b0, last_record: 1'b0, length_error: 1'b0};
    unique case (phase_q)
      PH_COUNT: begin
        records_left_d    = byte_i;
        res_valid_o       = 1'b1;
        res_o.value       = {24'd0, byte_i};
        res_o.last_record = (byte_i == 8'd0);
        phase_d           = (byte_i == 8'd0) ? PH_COUNT : PH_HEADER;
      end
      PH_HEADER: begin
        last_d = byte_i[7];
        acc_d  = '0;
        if (hdr_type == TYPE_UNS || hdr_type == TYPE_SGN) begin
          signed_d     = hdr_type[0];
          field_size_d = byte_i[4:0];
          bytes_left_d = {1'b0, byte_i[4:0]};
          if (byte_i[4:0] == 5'd0) begin
            res_valid_o          = 1'b1;
            res_o.kind           = hdr_type[0] ? KIND_SGN : KIND_UNS;
            res_o.end_of_field   = 1'b1;
            res_o.last_in_record = byte_i[7];
            res_o.last_record    = close_last_rec;
            phase_d              = close_phase;
            if (byte_i[7]) records_left_d = rec_dec;
          end else begin
            phase_d = PH_NUMBER;
          end
        end else begin
          bytes_left_d = byte_i[5:0];
          if (byte_i[5:0] == 6'd0) begin
            res_valid_o          = 1'b1;
            res_o.kind           = KIND_EMPTY;
            res_o.end_of_field   = 1'b1;
            res_o.last_in_record = byte_i[7];
            res_o.last_record    = close_last_rec;
            phase_d              = close_phase;
            if (byte_i[7]) records_left_d = rec_dec;
          end else begin
            phase_d = PH_STRING;
          end
        end
      end
      PH_NUMBER: begin
        acc_d        = acc_shift;
        bytes_left_d = left_dec;
        if (left_dec == 6'd0) begin
          res_valid_o          = 1'b1;
          res_o.kind           = signed_q ? KIND_SGN : KIND_UNS;
          res_o.value          = num_value;
          res_o.end_of_field   = 1'b1;
          res_o.last_in_record = last_q;
          res_o.last_record    = close_last_rec;
          res_o.length_error   = (field_size_q > MAX_NUM_BYTES);
          phase_d              = close_phase;
          if (last_q) records_left_d = rec_dec;
        end
      end
      PH_STRING: begin
        bytes_left_d = left_dec;
        res_valid_o  = 1'b1;
        res_o.kind   = KIND_CHAR;
        res_o.value  = {24'd0, byte_i};
        if (left_dec == 6'd0) begin
          res_o.end_of_field   = 1'b1;
          res_o.last_in_record = last_q;
          res_o.last_record    = close_last_rec;
          phase_d              = close_phase;
          if (last_q) records_left_d = rec_dec;
        end
      end
      default: phase_d = PH_COUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_COUNT;
      records_left_q <= '0;
      bytes_left_q   <= '0;
      acc_q          <= '0;
      field_size_q   <= '0;
      signed_q       <= 1'b0;
      last_q         <= 1'b0;
    end else if (step_i) begin
      phase_q        <= phase_d;
      records_left_q <= records_left_d;
      bytes_left_q   <= bytes_left_d;
      acc_q          <= acc_d;
      field_size_q   <= field_size_d;
      signed_q       <= signed_d;
      last_q         <= last_d;
    end
  end

  // a record is open whenever a count byte is not expected
  a_records_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_COUNT |-> records_left_q != 8'd0)
    else $error("records_left zero outside count phase");

  // value and string phases always have bytes still to come
  a_bytes_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_NUMBER || phase_q == PH_STRING) |-> bytes_left_q != 6'd0)
    else $error("bytes_left zero inside a field");

  // a count result never closes a field
  a_count_no_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == KIND_COUNT) |-> !res_o.end_of_field)
    else $error("count result flagged end of field");

  // closing the final record always returns to the count phase
  a_last_rec_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_valid_o && res_o.last_record) |=> phase_q == PH_COUNT)
    else $error("last record did not return to count phase");

endmodule

`default_nettype wire

[rtl/compact_record_decoder.sv]
// Top level of the compact record decoder: stream ports, input and result registers.
`default_nettype none

// Decodes a compact record stream one byte per beat: a record count byte, then
// for each field a header byte followed by big-endian value bytes or string
// characters. Each input beat is captured in an input register, decoded by the
// state machine in a single step and yields at most one result beat, which sits
// in the result register until taken. One byte is accepted per cycle while the
// result side keeps up; each beat passes the input register, then the result register.
// While a result waits downstream the input register takes at most one more
// beat and then holds the input off until the result is taken.
// tuser carries the result kind; tlast marks the result that completes the
// final record, and also the result of a zero record count.
module compact_record_decoder (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] value, [32] end_of_field,
                                        // [33] last_in_record, [34] length_error,
                                        // [39:35] zero
  output logic [2:0]  m_axis_tuser_o,   // [2:0] kind
  output logic        m_axis_tlast_o    // last_record
);
  import crd_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  result_t    out_res_q;

  logic       step;
  logic       res_valid;
  result_t    res;

  assign step            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || step;

  crd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) in_valid_q <= s_axis_tvalid_i;
      if (step) begin
        out_valid_q <= res_valid;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) in_byte_q <= s_axis_tdata_i;
    if (step && res_valid) out_res_q <= res;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_res_q.length_error, out_res_q.last_in_record,
                            out_res_q.end_of_field, out_res_q.value};
  assign m_axis_tuser_o  = out_res_q.kind;
  assign m_axis_tlast_o  = out_res_q.last_record;

  // a held beat is decoded only once the result register has room
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !step)
    else $error("result overwritten while stalled");

  // a stalled input byte stays put until decoded
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !step) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("input beat lost before decode");

  // result register empties only by a downstream take or a resultless step
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> out_valid_q)
    else $error("result dropped while stalled");

endmodule

`default_nettype wire

[verif/crd_result_checker.sv]
// Result checker for the compact record decoder: predicts every result beat and compares.
module crd_result_checker
  import crd_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  input  wire         in_ready_i,
  input  wire  [7:0]  in_data_i,    // [7:0] in_byte
  input  wire         out_valid_i,
  input  wire         out_ready_i,
  input  wire  [39:0] out_data_i,   // [31:0] value, [32] end_of_field,
                                    // [33] last_in_record, [34] length_error
  input  wire  [2:0]  out_user_i,   // [2:0] kind
  input  wire         out_last_i,   // last_record
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned results_checked_o,
  output logic        awaiting_count_o
);

  typedef enum logic [1:0] {
    AWAIT_COUNT  = 2'd0,
    AWAIT_HEADER = 2'd1,
    IN_NUMBER    = 2'd2,
    IN_STRING    = 2'd3
  } parse_phase_e;

  parse_phase_e phase_q = AWAIT_COUNT;
  logic [7:0]   records_left;
  logic [5:0]   bytes_left;
  logic [31:0]  acc;
  logic [4:0]   num_size;
  logic         num_signed;
  logic         field_last;

  result_t      expected_results [$];
  int unsigned  fails;
  int unsigned  checked;

  // Ends a field; returns whether it completed the final record.
  function automatic logic close_field();
    if (!field_last) begin
      phase_q = AWAIT_HEADER;
      return 1'b0;
    end
    records_left = records_left - 8'd1;
    if (records_left == 8'd0) begin
      phase_q = AWAIT_COUNT;
      return 1'b1;
    end
    phase_q = AWAIT_HEADER;
    return 1'b0;
  endfunction

  // Advances the decode state by one stream byte; returns 1 when a result is due.
  function automatic logic decode_byte(input logic [7:0] b, output result_t r);
    logic [1:0]  ftype;
    logic [31:0] v;
    r = '0;
    case (phase_q)
      AWAIT_COUNT: begin
        records_left = b;
        r.kind = KIND_COUNT;
        r.value = {24'd0, b};
        r.last_record = (b == 8'd0);
        phase_q = (b == 8'd0) ? AWAIT_COUNT : AWAIT_HEADER;
        return 1'b1;
      end
      AWAIT_HEADER: begin
        ftype = b[6:5];
        field_last = b[7];
        acc = '0;
        if (ftype == TYPE_UNS || ftype == TYPE_SGN) begin
          num_signed = (ftype == TYPE_SGN);
          num_size = b[4:0];
          bytes_left = {1'b0, b[4:0]};
          if (num_size == 5'd0) begin
            r.kind = num_signed ? KIND_SGN : KIND_UNS;
            r.end_of_field = 1'b1;
            r.last_in_record = field_last;
            r.last_record = close_field();
            return 1'b1;
          end
          phase_q = IN_NUMBER;
          return 1'b0;
        end
        bytes_left = b[5:0];
        if (bytes_left == 6'd0) begin
          r.kind = KIND_EMPTY;
          r.end_of_field = 1'b1;
          r.last_in_record = field_last;
          r.last_record = close_field();
          return 1'b1;
        end
        phase_q = IN_STRING;
        return 1'b0;
      end
      IN_NUMBER: begin
        acc = {acc[23:0], b};
        bytes_left = bytes_left - 6'd1;
        if (bytes_left != 6'd0) return 1'b0;
        v = acc;
        // sign extension only for 1 to 3 byte signed values
        if (num_signed && num_size >= 5'd1 && num_size <= 5'd3 && v[num_size * 8 - 1])
          v = v | (32'hFFFF_FFFF << (num_size * 8));
        r.kind = num_signed ? KIND_SGN : KIND_UNS;
        r.value = v;
        r.length_error = (num_size > MAX_NUM_BYTES);
        r.end_of_field = 1'b1;
        r.last_in_record = field_last;
        r.last_record = close_field();
        return 1'b1;
      end
      default: begin
        bytes_left = bytes_left - 6'd1;
        r.kind = KIND_CHAR;
        r.value = {24'd0, b};
        if (bytes_left != 6'd0) return 1'b1;
        r.end_of_field = 1'b1;
        r.last_in_record = field_last;
        r.last_record = close_field();
        return 1'b1;
      end
    endcase
  endfunction

  task automatic report_field(input string what, input logic [31:0] want_v,
                              input logic [31:0] got_v, inout bit bad);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want_v, got_v);
      bad = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    bit      bad;
    if (!rst_ni) begin
      phase_q = AWAIT_COUNT;
      records_left = '0;
      bytes_left = '0;
      acc = '0;
      num_size = '0;
      num_signed = 1'b0;
      field_last = 1'b0;
      expected_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.kind = kind_e'(out_user_i);
        got.value = out_data_i[31:0];
        got.end_of_field = out_data_i[32];
        got.last_in_record = out_data_i[33];
        got.length_error = out_data_i[34];
        got.last_record = out_last_i;
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected: kind %0d value %h",
                   $time, out_user_i, got.value);
          fails++;
        end else begin
          want = expected_results.pop_front();
          bad = 1'b0;
          report_field("kind", 32'(want.kind), 32'(got.kind), bad);
          report_field("value", want.value, got.value, bad);
          report_field("end_of_field", 32'(want.end_of_field), 32'(got.end_of_field),
                       bad);
          report_field("last_in_record", 32'(want.last_in_record),
                       32'(got.last_in_record), bad);
          report_field("last_record", 32'(want.last_record), 32'(got.last_record), bad);
          report_field("length_error", 32'(want.length_error), 32'(got.length_error),
                       bad);
          if (bad) fails++;
          checked++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (decode_byte(in_data_i, want)) expected_results.push_back(want);
      end
    end
    fail_count_o <= fails;
    pending_o <= expected_results.size();
    results_checked_o <= checked;
    awaiting_count_o <= (phase_q == AWAIT_COUNT);
  end

endmodule

[verif/compact_record_decoder_test.sv]
// Testbench top for the compact record decoder: clock, reset, stream stimulus and verdict.
module compact_record_decoder_test;
  import crd_pkg::*;

  localparam logic [1:0]  TYPE_STR      = 2'd2;
  localparam logic [1:0]  TYPE_STR_LONG = 2'd3;
  localparam int unsigned BYTE_BUDGET   = 1100;
  localparam int unsigned HOLD_AT       = 600;
  localparam int unsigned HOLD_CYCLES   = 400;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_checked;
  logic        awaiting_count;

  int unsigned bytes_sent;
  int unsigned broken_runs;
  bit          sender_gaps;
  logic [7:0]  stream_q [$];

  logic [7:0]  directed_bytes [25] = '{
    8'h00,                                // zero record count
    8'h03,                                // three records
    8'h00, 8'h20,                         // zero-byte unsigned and signed numbers
    8'h21, 8'h80,                         // signed 1 byte, negative
    8'h23, 8'h7F, 8'hFF, 8'hFF,           // signed 3 bytes, positive
    8'h40,                                // empty string
    8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF,    // unsigned 4 bytes, last field
    8'hA5, 8'h80, 8'h00, 8'h00, 8'h00, 8'h01, // overlong signed, last field
    8'hC2, 8'h41, 8'h7E                   // two-char string, final record
  };

  compact_record_decoder DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  crd_result_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (s_axis_tvalid),
    .in_ready_i        (s_axis_tready),
    .in_data_i         (s_axis_tdata),
    .out_valid_i       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_data_i        (m_axis_tdata),
    .out_user_i        (m_axis_tuser),
    .out_last_i        (m_axis_tlast),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .results_checked_o (results_checked),
    .awaiting_count_o  (awaiting_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("timeout: %0d results still expected", pending);
    $display("*** FAILED ***");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  // result side: random stalls, calm stretches, one long hold-off
  initial begin : result_sink
    int unsigned cyc;
    int unsigned stall;
    int unsigned next_mode;
    bit          calm;
    bit          hold_done;
    m_axis_tready = 1'b0;
    cyc = 0;
    next_mode = 0;
    calm = 1'b0;
    hold_done = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (cyc >= next_mode) begin
        calm = ($urandom_range(0, 3) == 0);
        next_mode = cyc + 128;
      end
      if (!hold_done && cyc >= HOLD_AT) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        cyc += HOLD_CYCLES;
      end
      stall = calm ? 0 : pick_gap();
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        cyc += stall;
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      cyc++;
    end
  end

  initial begin : stimulus
    int unsigned r;
    int unsigned n_rec;
    int unsigned n_fld;
    int unsigned len;
    int unsigned n;
    int unsigned cut;
    int unsigned idx;
    logic [1:0]  ftype;
    logic [7:0]  hdr;

    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    bytes_sent = 0;
    broken_runs = 0;
    sender_gaps = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_bytes[k]) send_byte(directed_bytes[k]);

    while (bytes_sent < BYTE_BUDGET) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      stream_q.delete();
      r = $urandom_range(0, 9);
      n_rec = (r == 0) ? 0 : (r < 9) ? $urandom_range(1, 3) : $urandom_range(4, 8);
      stream_q.push_back(8'(n_rec));
      for (int i = 0; i < n_rec; i++) begin
        n_fld = $urandom_range(1, 4);
        for (int j = 0; j < n_fld; j++) begin
          r = $urandom_range(0, 19);
          ftype = (r < 8) ? TYPE_UNS : (r < 14) ? TYPE_SGN : (r < 19) ? TYPE_STR : TYPE_STR_LONG;
          hdr = {(j == n_fld - 1), ftype, 5'd0};
          r = $urandom_range(0, 19);
          if (ftype == TYPE_UNS || ftype == TYPE_SGN) begin
            len = (r < 17) ? $urandom_range(0, 4) :
                  (r < 19) ? $urandom_range(5, 8) : $urandom_range(9, 31);
            hdr[4:0] = 5'(len);
          end else if (ftype == TYPE_STR) begin
            len = (r < 18) ? $urandom_range(0, 6) : $urandom_range(7, 31);
            hdr[4:0] = 5'(len);
          end else begin
            len = $urandom_range(32, 63);
            hdr[5:0] = 6'(len);
          end
          stream_q.push_back(hdr);
          repeat (len) begin
            r = $urandom_range(0, 7);
            stream_q.push_back((r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom));
          end
        end
      end

      if ($urandom_range(0, 7) == 0) begin
        broken_runs++;
        if ($urandom_range(0, 1) == 0) begin
          n = $urandom_range(1, 6);
          stream_q.delete();
          repeat (n) stream_q.push_back(8'($urandom));
        end else begin
          // truncated set with one flipped bit
          cut = (stream_q.size() > 1) ? $urandom_range(1, stream_q.size() - 1) : 1;
          while (stream_q.size() > cut) void'(stream_q.pop_back());
          idx = $urandom_range(0, stream_q.size() - 1);
          stream_q[idx] = stream_q[idx] ^ 8'(1 << $urandom_range(0, 7));
        end
        foreach (stream_q[k]) send_byte(stream_q[k]);
        // close fields until the decoder wants a count byte again
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (!awaiting_count) begin
          send_byte(8'h80);
          s_axis_tvalid <= 1'b0;
          @(posedge clk_i);
        end
      end else begin
        foreach (stream_q[k]) send_byte(stream_q[k]);
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("%0d stream bytes sent, %0d of them in broken or noisy runs, %0d results checked",
             bytes_sent, broken_runs, results_checked);
    $display("covered counts, all number sizes, strings, overlong fields and a long hold-off");
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
